[src/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// ffa_pkg: shared types for the first-fit max tree allocator
// Request/result payloads, kind codes, controller states and control structs.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned VAL_W  = 31;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned BCNT_W = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_PLACE = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  basket_index;
    logic [VAL_W-1:0]  capacity;
    logic [VAL_W-1:0]  fruit_size;
  } req_t;

  typedef struct packed {
    logic              placed;
    logic [IDX_W-1:0]  slot_found;
    logic [CNT_W-1:0]  unplaced_count;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_UP_RD,
    ST_UP_WAIT,
    ST_UP_WR,
    ST_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;       // capture request
    logic clr_start;   // begin clear sweep at node 0
    logic clr_step;    // write zero, advance sweep
    logic find_init;   // start descent at root
    logic find_rd;     // read both children of current node
    logic find_step;   // pick child / finish
    logic up_init;     // start leaf write
    logic up_rd;       // read sibling pair of current node
    logic up_wr;       // write pending value into node, carry max up
    logic emit;        // drive result strobe
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic find_done;
    logic found;
    logic at_root;
  } sts_t;

endpackage

[src/ffa_ctrl.sv]
// ----------------------------------------------------------------------------
// ffa_ctrl: sequencer for the allocator
// Steps clear sweeps, tree descents and leaf-to-root rewrites.
// ----------------------------------------------------------------------------
module ffa_ctrl import ffa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  kind_t kind,
  input  logic  load_ok,
  input  sts_t  sts,
  output ctl_t  ctl,
  output logic  busy
);

  state_t state, state_next;
  logic   is_place, is_place_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      is_place <= 1'b0;
    end else begin
      state    <= state_next;
      is_place <= is_place_next;
    end
  end

  always_comb begin
    state_next    = state;
    is_place_next = is_place;
    ctl           = '0;
    busy          = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          case (kind)
            KIND_LOAD: begin
              if (load_ok) begin
                ctl.up_init   = 1'b1;
                is_place_next = 1'b0;
                state_next    = ST_UP_RD;
              end
            end
            KIND_PLACE: begin
              ctl.find_init = 1'b1;
              state_next    = ST_FIND_RD;
            end
            KIND_CLEAR: begin
              ctl.clr_start = 1'b1;
              state_next    = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_FIND_RD: begin
        ctl.find_rd = 1'b1;
        state_next  = ST_FIND_CHK;
      end
      ST_FIND_CHK: begin
        ctl.find_step = 1'b1;
        if (sts.find_done) begin
          if (sts.found) begin
            ctl.up_init   = 1'b1;
            is_place_next = 1'b1;
            state_next    = ST_UP_RD;
          end else begin
            state_next = ST_RESULT;
          end
        end else begin
          state_next = ST_FIND_RD;
        end
      end
      ST_UP_RD: begin
        if (sts.at_root) begin
          state_next = is_place ? ST_RESULT : ST_IDLE;
        end else begin
          ctl.up_rd  = 1'b1;
          state_next = ST_UP_WAIT;
        end
      end
      ST_UP_WAIT: state_next = ST_UP_WR;
      ST_UP_WR: begin
        ctl.up_wr  = 1'b1;
        state_next = ST_UP_RD;
      end
      ST_RESULT: begin
        ctl.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> state == ST_IDLE) else $error("result not followed by idle");
  a_latch_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.latch |-> !busy) else $error("request taken while busy");
  a_wr_after_wait: assert property (@(posedge clk) disable iff (rst)
    ctl.up_wr |-> $past(state) == ST_UP_WAIT) else $error("write without read");
`endif

endmodule

[src/ffa_dp.sv]
// ----------------------------------------------------------------------------
// ffa_dp: tree memory, descent and update datapath
// Heap-ordered max tree in one memory; node 1 is the root, leaves at N+i.
// Each word holds two sibling nodes so one read gives both children.
// ----------------------------------------------------------------------------
module ffa_dp import ffa_pkg::*; #(
  parameter int unsigned VW      = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  input  req_t              req,
  input  logic [BCNT_W-1:0] basket_count,
  output sts_t              sts,
  output logic              res_valid,
  output res_t              res
);

  localparam int unsigned LEVELS = IDX_W;
  localparam int unsigned NB     = 1 << LEVELS;
  localparam int unsigned NODEW  = LEVELS + 1;   // node number 1..2N-1
  localparam int unsigned LIMW   = LEVELS + 1;
  localparam logic [LEVELS-1:0] LAST_DEPTH = LEVELS'(LEVELS - 1);

  // pair memory: word p holds nodes 2p (lo) and 2p+1 (hi), p in 0..N-1
  logic [2*VW-1:0] mem [NB];
  logic [2*VW-1:0] rd;
  logic [LEVELS-1:0] raddr, waddr;
  logic [2*VW-1:0] wdata;
  logic            we, re;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd <= mem[raddr];
  end

  logic [VW-1:0]      key;
  logic [NODEW-1:0]   node;
  logic [LIMW-1:0]    lim;
  logic [LEVELS-1:0]  clr_ptr;
  logic [CNT_W-1:0]   tally;
  logic               found;
  logic [LEVELS-1:0]  leaf_idx;

  // upward pass: pending value written into node
  logic [VW-1:0] upval;
  logic [VW-1:0] sib, upmax;

  // descent bookkeeping: subtree lo index of current node at depth
  logic [LEVELS-1:0] depth;

  always_comb begin
    re    = ctl.find_rd || ctl.up_rd;
    // descent reads the children of node, the upward pass reads node's own pair
    raddr = ctl.find_rd ? node[LEVELS-1:0] : node[NODEW-1:1];
    we    = 1'b0;
    waddr = node[NODEW-1:1];
    wdata = rd;
    if (ctl.clr_step) begin
      we    = 1'b1;
      waddr = clr_ptr;
      wdata = '0;
    end else if (ctl.up_wr) begin
      we = 1'b1;
      if (node[0]) wdata = {upval, rd[VW-1:0]};
      else         wdata = {rd[2*VW-1:VW], upval};
    end
  end

  // parent value is max of the written node and its sibling
  assign sib   = node[0] ? rd[VW-1:0] : rd[2*VW-1:VW];
  assign upmax = (upval > sib) ? upval : sib;

  // child values of node: read pair at node (children 2n, 2n+1 = word n)
  logic [VW-1:0] lv, rv;
  logic [LIMW:0] lo_l, lo_r;
  logic          l_ok, r_ok;
  logic          descend;
  logic [LEVELS-1:0] leaf_pick;
  assign lv = rd[VW-1:0];
  assign rv = rd[2*VW-1:VW];

  // descent node index in tree of depth `depth`; subtree lo = (node - 2^d) << (L-d)
  logic [NODEW:0] child_l;
  assign child_l = {node, 1'b0};
  always_comb begin
    lo_l = (LIMW+1)'((child_l - (NODEW+1)'(2) * ((NODEW+1)'(1) << depth))
           << (LEVELS - 32'(depth) - 1));
    lo_r = lo_l + ((LIMW+1)'(1) << (LEVELS - 32'(depth) - 1));
    l_ok = (lv > key) && (lo_l < (LIMW+1)'(lim));
    r_ok = (rv > key) && (lo_r < (LIMW+1)'(lim));
  end

  assign descend   = l_ok || r_ok;
  assign leaf_pick = l_ok ? lo_l[LEVELS-1:0] : lo_r[LEVELS-1:0];

  logic last_level;
  assign last_level = (depth == LAST_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr   <= '0;
      tally     <= '0;
      res_valid <= 1'b0;
      node      <= '0;
    end else begin
      res_valid <= ctl.emit;
      if (ctl.latch) begin
        key <= {1'b0, req.fruit_size[VW-2:0]};
        lim <= (basket_count > BCNT_W'(NB)) ? LIMW'(NB) : LIMW'(basket_count);
      end
      if (ctl.clr_start) begin
        clr_ptr <= '0;
      end else if (ctl.clr_step) begin
        clr_ptr <= clr_ptr + 1'b1;
      end
      // miss: no child passes, tally saturates
      if (ctl.clr_start) begin
        tally <= '0;
      end else if (ctl.find_step && !descend && tally != '1) begin
        tally <= tally + 1'b1;
      end
      if (ctl.find_init) begin
        depth <= '0;
        found <= 1'b0;
      end else if (ctl.find_step && descend) begin
        depth <= depth + 1'b1;
        if (last_level) begin
          found    <= 1'b1;
          leaf_idx <= leaf_pick;
        end
      end
      if (ctl.up_init) begin
        if (ctl.latch) begin
          node  <= {1'b1, req.basket_index};
          upval <= {1'b0, req.capacity[VW-2:0]} + 1'b1;
        end else begin
          node  <= {1'b1, leaf_pick};
          upval <= '0;
        end
      end else if (ctl.find_init) begin
        node <= NODEW'(1);
      end else if (ctl.find_step && descend) begin
        node <= l_ok ? child_l[NODEW-1:0] : {child_l[NODEW-1:1], 1'b1};
      end else if (ctl.up_wr) begin
        node  <= node >> 1;
        upval <= upmax;
      end
    end
  end

  // root's value is word 0 hi; root has no sibling write beyond node 1
  assign sts.clr_last  = (clr_ptr == '1);
  assign sts.find_done = last_level || !descend;
  assign sts.found     = last_level && descend;
  assign sts.at_root   = (node == '0);

  always_comb begin
    res.placed         = found;
    res.slot_found     = found ? leaf_idx : '0;
    res.unplaced_count = tally;
  end

`ifndef NO_ASSERTIONS
  a_clr_range: assert property (@(posedge clk) disable iff (rst)
    ctl.clr_step |-> !ctl.up_wr) else $error("clear overlaps update");
  a_tally_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(ctl.clr_start) && !$past(rst) |-> tally >= $past(tally))
    else $error("tally went down");
  a_res_one: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> !res_valid) else $error("result held two cycles");
`endif

endmodule

[src/first_fit_max_tree_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_max_tree_allocator: first-fit slot allocator over a max tree
// Loads slot capacities, places requests in the lowest fitting slot, clears.
// ----------------------------------------------------------------------------
// channel   | handshake          | payload
// request   | start / busy       | req    (req_t)
// result    | done strobe        | res    (res_t)
// config    | cfg_we             | cfg_data (basket_count)
//
// Sequence (L = tree levels = 10): a place request reads memory then compares
// at each level on the way down, then reads, waits and writes each node while
// rewriting the leaf-to-root path (L+1 nodes), sees the root and emits; done
// follows the last busy cycle. A miss stops the descent early and emits. A load
// rewrites the leaf-to-root path and gives no result. A clear, and reset,
// sweep all 2**L words of the tree memory, busy high.
// Results appear for one cycle on done; the receiver cannot stall.
module first_fit_max_tree_allocator import ffa_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  req_t              req,
  output logic              done,
  output res_t              res,
  input  logic              cfg_we,
  input  logic [BCNT_W-1:0] cfg_data
);

  localparam int unsigned NB = 1 << IDX_W;

  logic [BCNT_W-1:0] basket_count;
  ctl_t ctl;
  sts_t sts;
  logic load_ok;

  always_ff @(posedge clk) begin
    if (rst) basket_count <= '0;
    else if (cfg_we) basket_count <= cfg_data;
  end

  // loads beyond the tree size are dropped
  assign load_ok = (32'(req.basket_index) < NB);

  ffa_ctrl u_ctrl (
    .clk, .rst, .start,
    .kind    (kind_t'(req.kind)),
    .load_ok,
    .sts, .ctl, .busy
  );

  ffa_dp #(.VW(VALUE_WIDTH)) u_dp (
    .clk, .rst, .ctl, .req, .basket_count, .sts,
    .res_valid (done),
    .res
  );

`ifndef NO_ASSERTIONS
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !done) else $error("result too early");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> !busy || $past(rst)) else $error("config during work");
`endif

endmodule
